// ===== rtl/hll_pkg.sv =====
// Shared types and constants for the HyperLogLog sparse/dense register update block.
// No dependencies; imported by hll_merge, hll_sparse_to_dense_update and the testbench.
package hll_pkg;

  // Field widths on the stream ports
  localparam int IDX_FIELD_W = 14;
  localparam int RANK_W      = 6;
  localparam int HELD_W      = 9;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 24;

  // Parameter defaults
  localparam int DEF_INDEX_BITS = 14;
  localparam int DEF_MAX_PAIRS  = 256;

  // One register array entry: presence mark for sparse bookkeeping plus value
  typedef struct packed {
    logic              present;
    logic [RANK_W-1:0] value;
  } entry_t;

  // Bookkeeping decisions from the merge logic
  typedef struct packed {
    logic append;    // new sparse pair taken
    logic go_dense;  // list full and index absent: switch to dense mode
  } merge_stat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } ctrl_state_t;

endpackage

// ===== rtl/hll_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hll_merge.sv =====
// Merge of one update into the stored register entry, with sparse-list bookkeeping.
// Depends on hll_pkg (entry_t, merge_stat_t).
module hll_merge (
  input  hll_pkg::entry_t              stored,
  input  logic [hll_pkg::RANK_W-1:0]   rank,
  input  logic                         dense,
  input  logic                         full,
  output hll_pkg::entry_t              wr_entry,
  output logic [hll_pkg::RANK_W-1:0]   result,
  output hll_pkg::merge_stat_t         stat
);
  import hll_pkg::*;

  logic              hit;
  logic [RANK_W-1:0] merged;

  // In dense mode every entry counts; unwritten ones hold zero
  assign hit    = dense || stored.present;
  assign merged = (hit && (stored.value > rank)) ? stored.value : rank;

  // Decide the new entry and the list bookkeeping
  always_comb begin
    wr_entry.present = 1'b1;
    wr_entry.value   = merged;
    result           = merged;
    stat.append      = !hit && !full;
    stat.go_dense    = !hit && full;
  end

endmodule

// ===== rtl/hll_sparse_to_dense_update.sv =====
// Top level of the HyperLogLog register update block: controller, register array, output stage.
// Depends on hll_pkg, hll_ram and hll_merge.
//
// Each request carries a register index and a rank and yields one result: the register's
// new value, the mode, the number of sparse pairs held and a conversion flag. The registers
// live in one array of 2^INDEX_BITS entries, each with a presence mark, so the sparse pairs
// and the dense array share storage and the switch to dense mode needs no copy. An update
// reads the entry through the array's registered read port, then merges and writes it back;
// the write-back waits while the output stage is full, and a new request is accepted only
// after the write-back of the last one. After reset a clearing pass writes every entry once,
// during which s_tready stays low.
module hll_sparse_to_dense_update #(
  parameter int INDEX_BITS = hll_pkg::DEF_INDEX_BITS,
  parameter int MAX_PAIRS  = hll_pkg::DEF_MAX_PAIRS
) (
  input  logic                            clk,
  input  logic                            rst,
  // request: [13:0] reg_index, [19:14] rank, [23:20] zero
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hll_pkg::S_TDATA_W-1:0]   s_tdata,
  // result: [5:0] reg_value, [6] dense_now, [15:7] pairs_held, [16] converted, [23:17] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [hll_pkg::M_TDATA_W-1:0]   m_tdata
);
  import hll_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int PAD_W = M_TDATA_W - (RANK_W + 1 + HELD_W + 1);

  ctrl_state_t state, state_next;

  logic [INDEX_BITS-1:0] clr_addr;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] idx_q;
  logic [RANK_W-1:0]     rank_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  dense_mode;
  logic                  dense_next;
  logic                  full;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  entry_t                ram_wdata;
  logic                  ram_re;
  entry_t                ram_rdata;

  entry_t                wr_entry;
  logic [RANK_W-1:0]     result;
  merge_stat_t           stat;

  logic                  load_out;
  logic                  accept;

  logic [RANK_W-1:0]     reg_value_q;
  logic                  dense_q;
  logic [HELD_W-1:0]     held_q;
  logic                  conv_q;

  // Request fields
  assign idx    = INDEX_BITS'(s_tdata[IDX_FIELD_W-1:0]);
  assign accept = s_tvalid && s_tready;
  assign full   = (count == CNT_W'(MAX_PAIRS));

  // Register array
  hll_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Merge the read entry with the held rank
  hll_merge u_merge (
    .stored   (ram_rdata),
    .rank     (rank_q),
    .dense    (dense_mode),
    .full     (full),
    .wr_entry (wr_entry),
    .result   (result),
    .stat     (stat)
  );

  // Mode and pair count after this update
  always_comb begin
    count_next = count;
    dense_next = dense_mode;
    if (stat.go_dense) begin
      count_next = '0;
      dense_next = 1'b1;
    end else if (stat.append) begin
      count_next = count + CNT_W'(1);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and array control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = wr_entry;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        // hold until the output stage has room
        if (!m_tvalid || m_tready) begin
          ram_we     = 1'b1;
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + INDEX_BITS'(1);
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q  <= idx;
      rank_q <= s_tdata[IDX_FIELD_W +: RANK_W];
    end
  end

  // Mode and pair count
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      dense_mode <= 1'b0;
    end else if (load_out) begin
      count      <= count_next;
      dense_mode <= dense_next;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      reg_value_q <= result;
      dense_q     <= dense_next;
      held_q      <= HELD_W'(count_next);
      conv_q      <= stat.go_dense;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, conv_q, held_q, dense_q, reg_value_q};

  // Dense mode holds until reset
  a_dense_sticky: assert property (@(posedge clk) disable iff (rst)
    dense_mode |=> dense_mode)
    else $error("dense mode dropped");

  // Conversion leaves an empty list, dense mode and a pending result
  a_convert: assert property (@(posedge clk) disable iff (rst)
    (load_out && stat.go_dense) |=> (dense_mode && (count == '0) && m_tvalid && conv_q))
    else $error("conversion bookkeeping wrong");

  // The pair count stays within the list size and is zero in dense mode
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(MAX_PAIRS)) && (!dense_mode || (count == '0)))
    else $error("pair count out of range");

  // An accepted request is followed by the write-back step
  a_accept_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RMW))
    else $error("accepted request not processed");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for hll_sparse_to_dense_update: directed rows, then random requests.
// Depends on hll_pkg and the RTL top level; carries its own sparse/dense register predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hll_pkg::*;

  localparam int INDEX_BITS      = DEF_INDEX_BITS;
  localparam int MAX_PAIRS       = DEF_MAX_PAIRS;
  localparam int REG_COUNT       = 1 << INDEX_BITS;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int IDLE_LIMIT      = 60000;
  localparam int HOLD_OFF_AT     = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int NUM_DIRECTED    = 15;

  typedef struct packed {
    logic [RANK_W-1:0] reg_value;
    logic              dense_now;
    logic [HELD_W-1:0] pairs_held;
    logic              converted;
  } update_result_t;

  // One directed request; pinned rows carry a hand-written result
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] idx;
    logic [RANK_W-1:0]      rank;
    logic                   pinned;
    update_result_t         want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [13:0] reg_index, [19:14] rank, [23:20] zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [5:0] reg_value, [6] dense_now, [15:7] pairs_held, [16] converted

  // Predictor state
  logic [IDX_FIELD_W-1:0] pair_idx [MAX_PAIRS];
  logic [RANK_W-1:0]      pair_val [MAX_PAIRS];
  int unsigned            pair_count = 0;
  bit                     dense_mode = 1'b0;
  logic [RANK_W-1:0]      dense_regs [REG_COUNT];

  update_result_t expected_results [$];
  int             fails         = 0;
  int             results_taken = 0;
  int             idle_cycles   = 0;
  bit             burst         = 1'b0;
  bit             hold_off_done = 1'b0;
  bit             cur_pinned;
  update_result_t cur_want;

  // Index bookkeeping for the random mix
  bit                     seen_idx [REG_COUNT];
  logic [IDX_FIELD_W-1:0] used_list [$];

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // rank zero stored right after reset
    '{14'h0000, 6'd0,  1'b1, '{6'd0,  1'b0, 9'd1, 1'b0}},
    '{14'h3FFF, 6'd63, 1'b1, '{6'd63, 1'b0, 9'd2, 1'b0}},
    // existing pair raised, then kept by the maximum
    '{14'h0000, 6'd63, 1'b1, '{6'd63, 1'b0, 9'd2, 1'b0}},
    '{14'h3FFF, 6'd0,  1'b1, '{6'd63, 1'b0, 9'd2, 1'b0}},
    '{14'h0000, 6'd0,  1'b1, '{6'd63, 1'b0, 9'd2, 1'b0}},
    '{14'h2AAA, 6'h15, 1'b1, '{6'd21, 1'b0, 9'd3, 1'b0}},
    '{14'h1555, 6'h2A, 1'b1, '{6'd42, 1'b0, 9'd4, 1'b0}},
    '{14'h2AAA, 6'h2A, 1'b1, '{6'd42, 1'b0, 9'd4, 1'b0}},
    '{14'h1555, 6'h15, 1'b1, '{6'd42, 1'b0, 9'd4, 1'b0}},
    '{14'h0001, 6'd1,  1'b1, '{6'd1,  1'b0, 9'd5, 1'b0}},
    '{14'h2000, 6'd32, 1'b1, '{6'd32, 1'b0, 9'd6, 1'b0}},
    '{14'h0001, 6'd62, 1'b0, '0},
    '{14'h1FFF, 6'd31, 1'b0, '0},
    '{14'h3FFE, 6'd2,  1'b0, '0},
    '{14'h3F00, 6'd7,  1'b0, '0}
  };

  hll_sparse_to_dense_update u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one update to the predicted registers and return the result it yields
  function automatic update_result_t update_register(input logic [IDX_FIELD_W-1:0] idx,
                                                     input logic [RANK_W-1:0] rank);
    update_result_t r;
    bit             found;
    int             i;
    r     = '0;
    found = 1'b0;
    if (dense_mode) begin
      if (rank > dense_regs[idx]) dense_regs[idx] = rank;
      r.reg_value = dense_regs[idx];
    end else begin
      for (i = 0; i < pair_count; i++) begin
        if (!found && pair_idx[i] == idx) begin
          if (rank > pair_val[i]) pair_val[i] = rank;
          r.reg_value = pair_val[i];
          found       = 1'b1;
        end
      end
      if (!found) begin
        if (pair_count >= MAX_PAIRS) begin
          // list full and index absent: rebuild as a dense array, then merge
          for (i = 0; i < REG_COUNT; i++) dense_regs[i] = '0;
          for (i = 0; i < pair_count; i++) dense_regs[pair_idx[i]] = pair_val[i];
          pair_count = 0;
          dense_mode = 1'b1;
          if (rank > dense_regs[idx]) dense_regs[idx] = rank;
          r.reg_value = dense_regs[idx];
          r.converted = 1'b1;
        end else begin
          pair_idx[pair_count] = idx;
          pair_val[pair_count] = rank;
          pair_count++;
          r.reg_value = rank;
        end
      end
    end
    r.dense_now  = dense_mode;
    r.pairs_held = pair_count[HELD_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [IDX_FIELD_W-1:0] idx, input logic [RANK_W-1:0] rank,
                              input bit pinned, input update_result_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (!seen_idx[idx]) begin
      seen_idx[idx] = 1'b1;
      used_list.push_back(idx);
    end
    cur_pinned = pinned;
    cur_want   = want;
    s_tvalid  <= 1'b1;
    s_tdata   <= {{(S_TDATA_W - IDX_FIELD_W - RANK_W){1'b0}}, rank, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin : scoreboard
    update_result_t predicted;
    update_result_t got;
    update_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted = update_register(s_tdata[IDX_FIELD_W-1:0], s_tdata[IDX_FIELD_W +: RANK_W]);
        expected_results.push_back(cur_pinned ? cur_want : predicted);
      end
      if (m_tvalid && m_tready) begin
        got.reg_value  = m_tdata[RANK_W-1:0];
        got.dense_now  = m_tdata[RANK_W];
        got.pairs_held = m_tdata[RANK_W+1 +: HELD_W];
        got.converted  = m_tdata[RANK_W+1+HELD_W];
        if (expected_results.size() == 0) begin
          $error("result with no request pending: tdata=%h", m_tdata);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("reg_value", int'(want.reg_value), int'(got.reg_value));
          check_field("dense_now", int'(want.dense_now), int'(got.dense_now));
          check_field("pairs_held", int'(want.pairs_held), int'(got.pairs_held));
          check_field("converted", int'(want.converted), int'(got.converted));
        end
        results_taken++;
      end
    end
  end

  // End the run when nothing moves for too long (covers the clearing pass after reset)
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("hll_sparse_to_dense_update regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off to back up the block
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 5);
      if (!hold_off_done && results_taken >= HOLD_OFF_AT) begin
        stall         = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Request side: reset, directed rows, random requests, drain
  initial begin : request_source
    logic [IDX_FIELD_W-1:0] idx;
    logic [RANK_W-1:0]      rank;
    int                     n;
    bit                     fresh;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cur_pinned = 1'b0;
    cur_want   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_request(directed_rows[n].idx, directed_rows[n].rank, directed_rows[n].pinned,
                   directed_rows[n].want);
    end

    // Fill the list with a mix of new and repeated indexes until it converts, then
    // mostly hit known registers in dense mode
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      fresh = dense_mode ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 1) == 0);
      if (fresh || used_list.size() == 0) begin
        idx = IDX_FIELD_W'($urandom_range(0, REG_COUNT - 1));
      end else begin
        idx = used_list[$urandom_range(0, used_list.size() - 1)];
      end
      rank = RANK_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63));
      send_request(idx, rank, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("hll_sparse_to_dense_update regression: pass");
    end else begin
      $display("hll_sparse_to_dense_update regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hll_pkg.sv
rtl/hll_ram.sv
rtl/hll_merge.sv
rtl/hll_sparse_to_dense_update.sv
test/tb_top.sv
